// ===== hw/rtl/lsf_pkg.sv =====
`default_nettype none
package lsf_pkg;
    localparam logic [15:0] BROADCAST_ADDR = 16'hFFFF;

    typedef enum logic [2:0] {
        ACT_UNTOUCHED = 3'd0,
        ACT_ENQUEUED  = 3'd1,
        ACT_DROPPED   = 3'd2,
        ACT_DEQUEUED  = 3'd3,
        ACT_EMPTY     = 3'd4
    } t_action;

    typedef enum logic {
        OP_ARRIVAL = 1'b0,
        OP_TICK    = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LEARN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic        operation;
        logic [1:0]  ingress_port;
        logic [15:0] source_address;
        logic [15:0] destination_address;
        logic [15:0] frame_tag;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  report_port;
        logic [2:0]  action;
        logic [15:0] frame_out;
        logic        last;
    } t_out_word;

    // decision handed from the table front end to the queue back end
    typedef struct packed {
        logic        tick;
        logic        flood;
        logic        single;
        logic [1:0]  ingress;
        logic [1:0]  target;
        logic [15:0] tag;
    } t_cmd;
endpackage
`default_nettype wire

// ===== hw/rtl/learning_switch_forwarder.sv =====
`default_nettype none
// learning switch forwarder: the front end learns the source address and
// looks up the destination in a station table matched in parallel, stepping
// through scan, learn and emit states per word; a one-word command register
// then hands the decision to the queue back end, which reports on one port
// per cycle unless the output register is stalled (a port that dequeues also
// waits for the queue memory read); an item yields PORT_COUNT result words.
// the front end takes the next word while the back end is still reporting.
module learning_switch_forwarder #(
    parameter int PORT_COUNT    = 4,
    parameter int QUEUE_DEPTH   = 8,
    parameter int TABLE_ENTRIES = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  lsf_pkg::t_in_word   i_data,
    output logic                o_valid,
    input  wire                 i_stall,
    output lsf_pkg::t_out_word  o_data
);
    logic          w_cmd_valid, w_cmd_stall;
    lsf_pkg::t_cmd w_cmd;

    lsf_table #(.TABLE_ENTRIES(TABLE_ENTRIES), .PORT_COUNT(PORT_COUNT)) u_table (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_word(i_data),
        .o_valid(w_cmd_valid), .i_stall(w_cmd_stall), .o_cmd(w_cmd)
    );

    lsf_queues #(.PORT_COUNT(PORT_COUNT), .QUEUE_DEPTH(QUEUE_DEPTH)) u_queues (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_cmd_valid), .o_stall(w_cmd_stall), .i_cmd(w_cmd),
        .o_valid(o_valid), .i_stall(i_stall), .o_word(o_data)
    );

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");
    a_action_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.action <= lsf_pkg::ACT_EMPTY)
        else $error("bad action code");
    a_last_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.last == (32'(o_data.report_port) == PORT_COUNT - 1))
        else $error("last flag mismatch");
endmodule
`default_nettype wire

// ===== hw/rtl/lsf_table.sv =====
`default_nettype none
module lsf_table #(
    parameter int TABLE_ENTRIES = 64,
    parameter int PORT_COUNT    = 4
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  lsf_pkg::t_in_word   i_word,
    output logic                o_valid,
    input  wire                 i_stall,
    output lsf_pkg::t_cmd       o_cmd
);
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [15:0]          r_addr [TABLE_ENTRIES];
    logic [1:0]           r_port [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_vld;

    lsf_pkg::t_state r_state, n_state;
    lsf_pkg::t_in_word r_word;
    logic          r_src_hit, r_dst_hit, r_free_ok;
    logic [IW-1:0] r_src_idx, r_free_idx;
    logic [1:0]    r_dst_port;
    lsf_pkg::t_cmd r_cmd;
    logic          r_out_valid;

    // parallel match over the whole table
    logic          c_src_hit, c_dst_hit, c_free_ok;
    logic [IW-1:0] c_src_idx, c_dst_idx, c_free_idx;
    always_comb begin
        c_src_hit = 1'b0;
        c_dst_hit = 1'b0;
        c_free_ok = 1'b0;
        c_src_idx = '0;
        c_dst_idx = '0;
        c_free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (r_vld[i] && r_addr[i] == r_word.source_address) begin
                c_src_hit = 1'b1;
                c_src_idx = IW'(i);
            end
            if (r_vld[i] && r_addr[i] == r_word.destination_address) begin
                c_dst_hit = 1'b1;
                c_dst_idx = IW'(i);
            end
            if (!r_vld[i]) begin
                c_free_ok = 1'b1;
                c_free_idx = IW'(i);
            end
        end
    end

    logic c_valid_port, c_learn, c_src_bc, c_dst_bc;
    logic [1:0] c_dport;
    lsf_pkg::t_cmd c_cmd;
    always_comb begin
        c_valid_port = ({30'd0, r_word.ingress_port} < PORT_COUNT);
        c_src_bc = (r_word.source_address == lsf_pkg::BROADCAST_ADDR);
        c_dst_bc = (r_word.destination_address == lsf_pkg::BROADCAST_ADDR);
        c_learn = c_valid_port && !c_src_bc && (r_src_hit || r_free_ok);
        // a fresh entry or a moved one may hold the destination itself
        if (c_learn && r_word.source_address == r_word.destination_address)
            c_dport = r_word.ingress_port;
        else
            c_dport = r_dst_port;
        c_cmd = '0;
        c_cmd.tick = (r_word.operation == lsf_pkg::OP_TICK);
        c_cmd.ingress = r_word.ingress_port;
        c_cmd.tag = r_word.frame_tag;
        c_cmd.target = c_dport;
        if (!c_cmd.tick && c_valid_port) begin
            if (c_dst_bc || !(r_dst_hit || (c_learn &&
                    r_word.source_address == r_word.destination_address)))
                c_cmd.flood = 1'b1;
            else if ({30'd0, c_dport} >= PORT_COUNT)
                c_cmd.flood = 1'b1;
            else if (c_dport != r_word.ingress_port)
                c_cmd.single = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lsf_pkg::ST_IDLE:  if (i_valid) n_state = lsf_pkg::ST_SCAN;
            lsf_pkg::ST_SCAN:  n_state = lsf_pkg::ST_LEARN;
            lsf_pkg::ST_LEARN: n_state = lsf_pkg::ST_EMIT;
            lsf_pkg::ST_EMIT:  if (!r_out_valid || !i_stall) n_state = lsf_pkg::ST_IDLE;
            default:           n_state = lsf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall = (r_state != lsf_pkg::ST_IDLE);
        o_valid = r_out_valid;
        o_cmd   = r_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lsf_pkg::ST_IDLE;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == lsf_pkg::ST_EMIT && (!r_out_valid || !i_stall))
                r_out_valid <= 1'b1;
            else if (r_out_valid && !i_stall)
                r_out_valid <= 1'b0;
            if (r_state == lsf_pkg::ST_LEARN &&
                    r_word.operation == lsf_pkg::OP_ARRIVAL && c_learn) begin
                if (r_src_hit) begin
                    r_port[r_src_idx] <= r_word.ingress_port;
                end else begin
                    r_vld[r_free_idx]  <= 1'b1;
                    r_addr[r_free_idx] <= r_word.source_address;
                    r_port[r_free_idx] <= r_word.ingress_port;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lsf_pkg::ST_IDLE && i_valid) r_word <= i_word;
        if (r_state == lsf_pkg::ST_SCAN) begin
            r_src_hit  <= c_src_hit;
            r_src_idx  <= c_src_idx;
            r_dst_hit  <= c_dst_hit;
            r_dst_port <= r_port[c_dst_idx];
            r_free_ok  <= c_free_ok;
            r_free_idx <= c_free_idx;
        end
        // the command register changes only once the previous command has left
        if (r_state == lsf_pkg::ST_EMIT && (!r_out_valid || !i_stall)) r_cmd <= c_cmd;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/lsf_queues.sv =====
`default_nettype none
module lsf_queues #(
    parameter int PORT_COUNT  = 4,
    parameter int QUEUE_DEPTH = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  lsf_pkg::t_cmd       i_cmd,
    output logic                o_valid,
    input  wire                 i_stall,
    output lsf_pkg::t_out_word  o_word
);
    localparam int PW = 2;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = (PORT_COUNT * QUEUE_DEPTH > 1) ? $clog2(PORT_COUNT * QUEUE_DEPTH) : 1;

    logic [15:0]   r_mem [PORT_COUNT * QUEUE_DEPTH];
    logic [QW-1:0] r_head [PORT_COUNT];
    logic [CW-1:0] r_count [PORT_COUNT];

    logic          r_busy, r_rd_pend;
    lsf_pkg::t_cmd r_cmd;
    logic [PW-1:0] r_port;
    logic          r_out_valid;
    lsf_pkg::t_out_word r_out;
    logic [15:0]   r_rd_data;
    logic [2:0]    r_pend_act;
    logic [PW-1:0] r_pend_port;

    logic [CW-1:0] c_cnt;
    logic [QW-1:0] c_hd, c_tail, c_hd_next;
    logic [QW:0]   c_sum;
    logic [AW-1:0] c_base;
    logic          c_go, c_touch, c_last;
    logic [2:0]    c_act;

    always_comb begin
        c_cnt  = r_count[r_port];
        c_hd   = r_head[r_port];
        c_sum  = {1'b0, c_hd} + (QW + 1)'(c_cnt);
        c_tail = ({{(31 - QW){1'b0}}, c_sum} >= QUEUE_DEPTH) ? QW'(c_sum - QUEUE_DEPTH)
                                                             : QW'(c_sum);
        c_hd_next = (c_hd == QW'(QUEUE_DEPTH - 1)) ? '0 : c_hd + 1'b1;
        c_base = AW'(r_port) * AW'(QUEUE_DEPTH);
        c_last = ({30'd0, r_port} == PORT_COUNT - 1);
        c_touch = r_cmd.flood ? (r_port != r_cmd.ingress)
                              : (r_cmd.single && r_port == r_cmd.target);
        if (r_cmd.tick)
            c_act = (c_cnt == '0) ? lsf_pkg::ACT_EMPTY : lsf_pkg::ACT_DEQUEUED;
        else if (!c_touch)
            c_act = lsf_pkg::ACT_UNTOUCHED;
        else if ({{(32 - CW){1'b0}}, c_cnt} >= QUEUE_DEPTH)
            c_act = lsf_pkg::ACT_DROPPED;
        else
            c_act = lsf_pkg::ACT_ENQUEUED;
        // one port a cycle, waiting while a queue read is pending or a full output register is stalled
        c_go = r_busy && !r_rd_pend && (!r_out_valid || !i_stall);
    end

    assign o_stall = r_busy;
    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_port      <= '0;
            for (int p = 0; p < PORT_COUNT; p++) begin
                r_head[p]  <= '0;
                r_count[p] <= '0;
            end
        end else begin
            if (r_rd_pend || (c_go && c_act != lsf_pkg::ACT_DEQUEUED))
                r_out_valid <= 1'b1;
            else if (r_out_valid && !i_stall)
                r_out_valid <= 1'b0;
            if (!r_busy && i_valid) begin
                r_busy <= 1'b1;
                r_port <= '0;
            end
            if (r_rd_pend) begin
                r_rd_pend   <= 1'b0;
                if ({30'd0, r_pend_port} == PORT_COUNT - 1) r_busy <= 1'b0;
                else r_port <= r_pend_port + 1'b1;
            end else if (c_go) begin
                if (c_act == lsf_pkg::ACT_DEQUEUED) begin
                    r_rd_pend <= 1'b1;
                    r_head[r_port]  <= c_hd_next;
                    r_count[r_port] <= c_cnt - 1'b1;
                end else begin
                    if (c_act == lsf_pkg::ACT_ENQUEUED) r_count[r_port] <= c_cnt + 1'b1;
                    if (c_last) r_busy <= 1'b0;
                    else r_port <= r_port + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_valid) r_cmd <= i_cmd;
        r_rd_data <= r_mem[c_base + AW'(c_hd)];
        if (c_go && c_act == lsf_pkg::ACT_ENQUEUED)
            r_mem[c_base + AW'(c_tail)] <= r_cmd.tag;
        if (c_go) begin
            r_pend_act  <= c_act;
            r_pend_port <= r_port;
            r_out.report_port <= r_port;
            r_out.action      <= c_act;
            r_out.frame_out   <= (c_act == lsf_pkg::ACT_UNTOUCHED ||
                                  c_act == lsf_pkg::ACT_EMPTY) ? 16'd0 : r_cmd.tag;
            r_out.last        <= c_last;
        end
        if (r_rd_pend) begin
            r_out.report_port <= r_pend_port;
            r_out.action      <= r_pend_act;
            r_out.frame_out   <= r_rd_data;
            r_out.last        <= ({30'd0, r_pend_port} == PORT_COUNT - 1);
        end
    end
endmodule
`default_nettype wire

// ===== test/learning_switch_forwarder_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module learning_switch_forwarder_tb;
    localparam int NPORT = 4;
    localparam int QDEPTH = 8;
    localparam int NENTRY = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_RANDOM = 88;

    typedef struct {
        lsf_pkg::t_in_word w;
        bit                typed;
        lsf_pkg::t_action  act;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    lsf_pkg::t_in_word i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    lsf_pkg::t_out_word o_data;

    learning_switch_forwarder u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // switch state mirror
    logic [15:0] sta_addr [NENTRY];
    logic [1:0]  sta_port [NENTRY];
    logic        sta_used [NENTRY];
    logic [15:0] fifo_mem [NPORT][QDEPTH];
    int          fifo_head [NPORT];
    int          fifo_cnt [NPORT];

    lsf_pkg::t_out_word expected_words[$];
    int errors = 0;
    int words_seen = 0;
    int drops_seen = 0;
    int dequeues_seen = 0;
    int idle_cycles = 0;
    bit no_idle = 1'b0;

    function automatic int find_station(logic [15:0] addr);
        for (int i = 0; i < NENTRY; i++)
            if (sta_used[i] && sta_addr[i] == addr) return i;
        return -1;
    endfunction

    // predict the four report words of one item and update the mirror
    task automatic predict_forward(lsf_pkg::t_in_word w);
        lsf_pkg::t_action act [NPORT];
        logic [15:0] frm [NPORT];
        int idx;
        int target;
        lsf_pkg::t_out_word r;
        for (int p = 0; p < NPORT; p++) begin
            act[p] = lsf_pkg::ACT_UNTOUCHED;
            frm[p] = '0;
        end
        if (w.operation == lsf_pkg::OP_TICK) begin
            for (int p = 0; p < NPORT; p++) begin
                if (fifo_cnt[p] == 0) begin
                    act[p] = lsf_pkg::ACT_EMPTY;
                end else begin
                    act[p] = lsf_pkg::ACT_DEQUEUED;
                    frm[p] = fifo_mem[p][fifo_head[p]];
                    fifo_head[p] = (fifo_head[p] + 1) % QDEPTH;
                    fifo_cnt[p]--;
                end
            end
        end else begin
            if (w.source_address != lsf_pkg::BROADCAST_ADDR) begin
                idx = find_station(w.source_address);
                if (idx >= 0) begin
                    sta_port[idx] = w.ingress_port;
                end else begin
                    for (int i = 0; i < NENTRY; i++)
                        if (!sta_used[i]) begin
                            sta_used[i] = 1'b1;
                            sta_addr[i] = w.source_address;
                            sta_port[i] = w.ingress_port;
                            break;
                        end
                end
            end
            target = -1;
            if (w.destination_address != lsf_pkg::BROADCAST_ADDR) begin
                idx = find_station(w.destination_address);
                if (idx >= 0) target = sta_port[idx];
            end
            for (int p = 0; p < NPORT; p++) begin
                if ((target < 0 && p != w.ingress_port) ||
                    (target >= 0 && target != w.ingress_port && p == target)) begin
                    frm[p] = w.frame_tag;
                    if (fifo_cnt[p] >= QDEPTH) begin
                        act[p] = lsf_pkg::ACT_DROPPED;
                    end else begin
                        act[p] = lsf_pkg::ACT_ENQUEUED;
                        fifo_mem[p][(fifo_head[p] + fifo_cnt[p]) % QDEPTH] = w.frame_tag;
                        fifo_cnt[p]++;
                    end
                end
            end
        end
        for (int p = 0; p < NPORT; p++) begin
            r.report_port = 2'(p);
            r.action = act[p];
            r.frame_out = frm[p];
            r.last = (p == NPORT - 1);
            expected_words.push_back(r);
        end
    endtask

    // result side: random stall bursts, compare each word
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            lsf_pkg::t_out_word e;
            words_seen++;
            if (o_data.action == lsf_pkg::ACT_DROPPED) drops_seen++;
            if (o_data.action == lsf_pkg::ACT_DEQUEUED) dequeues_seen++;
            if (expected_words.size() == 0) begin
                $error("unexpected word %h", o_data);
                errors++;
            end else begin
                e = expected_words.pop_front();
                if (o_data.report_port !== e.report_port) begin
                    $error("report_port exp %0d got %0d", e.report_port, o_data.report_port);
                    errors++;
                end
                if (o_data.action !== e.action) begin
                    $error("action exp %0d got %0d", e.action, o_data.action);
                    errors++;
                end
                if (o_data.frame_out !== e.frame_out) begin
                    $error("frame_out exp %h got %h", e.frame_out, o_data.frame_out);
                    errors++;
                end
                if (o_data.last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, o_data.last);
                    errors++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 6);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress");
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // send one word; predicted at acceptance
    task automatic send_word(lsf_pkg::t_in_word w);
        int gap;
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_forward(w);
    endtask

    function automatic lsf_pkg::t_in_word mk(logic op, logic [1:0] ing, logic [15:0] s,
                                             logic [15:0] d, logic [15:0] t);
        lsf_pkg::t_in_word w;
        w.operation = op;
        w.ingress_port = ing;
        w.source_address = s;
        w.destination_address = d;
        w.frame_tag = t;
        return w;
    endfunction

    t_row directed [];
    logic [15:0] pool [8];
    lsf_pkg::t_in_word w;
    lsf_pkg::t_out_word typed_word;
    int drain;

    initial begin
        for (int i = 0; i < NENTRY; i++) sta_used[i] = 1'b0;
        for (int p = 0; p < NPORT; p++) begin
            fifo_head[p] = 0;
            fifo_cnt[p] = 0;
        end
        directed = '{
            // all empty after reset
            '{mk(lsf_pkg::OP_TICK, 2'd0, 16'h0000, 16'h0000, 16'h0000), 1'b1,
              lsf_pkg::ACT_EMPTY},
            // broadcast floods
            '{mk(lsf_pkg::OP_ARRIVAL, 2'd0, 16'h0001, 16'hFFFF, 16'hFFFF), 1'b0,
              lsf_pkg::ACT_UNTOUCHED},
            // broadcast source, known dst
            '{mk(lsf_pkg::OP_ARRIVAL, 2'd3, 16'hFFFF, 16'h0001, 16'h0000), 1'b0,
              lsf_pkg::ACT_UNTOUCHED},
            '{mk(lsf_pkg::OP_ARRIVAL, 2'd1, 16'h0002, 16'h0001, 16'h1234), 1'b0,
              lsf_pkg::ACT_UNTOUCHED},
            // filtered
            '{mk(lsf_pkg::OP_ARRIVAL, 2'd0, 16'h0001, 16'h0001, 16'h5555), 1'b1,
              lsf_pkg::ACT_UNTOUCHED},
            // station moves
            '{mk(lsf_pkg::OP_ARRIVAL, 2'd2, 16'h0001, 16'h0002, 16'hAAAA), 1'b0,
              lsf_pkg::ACT_UNTOUCHED},
            '{mk(lsf_pkg::OP_ARRIVAL, 2'd3, 16'hFFFE, 16'h0001, 16'h00FF), 1'b0,
              lsf_pkg::ACT_UNTOUCHED},
            // unknown dst
            '{mk(lsf_pkg::OP_ARRIVAL, 2'd3, 16'h8000, 16'h7FFF, 16'hFF00), 1'b0,
              lsf_pkg::ACT_UNTOUCHED},
            '{mk(lsf_pkg::OP_TICK, 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0,
              lsf_pkg::ACT_UNTOUCHED},
            '{mk(lsf_pkg::OP_TICK, 2'd1, 16'h5A5A, 16'hA5A5, 16'h0F0F), 1'b0,
              lsf_pkg::ACT_UNTOUCHED}
        };
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[k]) begin
            send_word(directed[k].w);
            // rows with a typed result replace the predicted words
            if (directed[k].typed) begin
                repeat (NPORT) void'(expected_words.pop_back());
                for (int p = 0; p < NPORT; p++) begin
                    typed_word.report_port = 2'(p);
                    typed_word.action = directed[k].act;
                    typed_word.frame_out = 16'h0000;
                    typed_word.last = (p == NPORT - 1);
                    expected_words.push_back(typed_word);
                end
            end
        end
        // fill queues until drops
        for (int k = 0; k < 12; k++)
            send_word(mk(lsf_pkg::OP_ARRIVAL, 2'(k % 4), 16'h0100 + 16'(k), 16'hFFFF,
                         16'(k)));
        // fill the station table past its size
        for (int k = 0; k < 70; k++)
            send_word(mk(lsf_pkg::OP_ARRIVAL, 2'($urandom_range(0, 3)), 16'h2000 + 16'(k),
                         16'h0001, 16'($urandom)));
        for (int k = 0; k < 8; k++) pool[k] = 16'($urandom);
        pool[0] = 16'h0001;
        pool[1] = 16'h2000;
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k > N_RANDOM - 30) no_idle = 1'b1;
            w = mk($urandom_range(0, 3) == 0, 2'($urandom_range(0, 3)),
                   $urandom_range(0, 3) == 0 ? 16'($urandom) : pool[$urandom_range(0, 7)],
                   $urandom_range(0, 5) == 0 ? 16'($urandom) :
                   ($urandom_range(0, 7) == 0 ? lsf_pkg::BROADCAST_ADDR
                                              : pool[$urandom_range(0, 7)]),
                   16'($urandom));
            send_word(w);
        end
        i_valid <= 1'b0;
        drain = 0;
        while (expected_words.size() != 0 && drain < 20000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (20) @(posedge i_clk);
        $display("covered %0d report words, %0d drops, %0d dequeues",
                 words_seen, drops_seen, dequeues_seen);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== learning_switch_forwarder.f =====
hw/rtl/lsf_pkg.sv
hw/rtl/lsf_table.sv
hw/rtl/lsf_queues.sv
hw/rtl/learning_switch_forwarder.sv
test/learning_switch_forwarder_tb.sv
